// ===== rtl/http_chunked_body_decoder_top_defines.svh =====
// Assertion macros shared by the chunked body decoder modules.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HCBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbd assertion failed");

// Check that cons holds in the cycle after ante.
`define HCBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbd assertion failed");

`endif

// ===== rtl/hcbd_pkg.sv =====
// Types, constants and helper functions of the chunked body decoder.
package hcbd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int HEX_RADIX_BITS = 4;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_HEX     = 3'd1,
        PH_EXT     = 3'd2,
        PH_LINE_CR = 3'd3,
        PH_DATA    = 3'd4,
        PH_DATA_CR = 3'd5,
        PH_DATA_LF = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_EARLY = 2'd2
    } kind_t;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       has_mark;
        kind_t      mark_kind;
    } entry_t;

    typedef struct packed {
        logic                      valid;
        logic [HEX_RADIX_BITS-1:0] value;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t r;
        logic [7:0] t;
        r = '0;
        t = '0;
        case (b) inside
            [8'h30:8'h39]:
            begin
                t = b - 8'h30;
                r.valid = 1'b1;
                r.value = t[HEX_RADIX_BITS-1:0];
            end
            [8'h61:8'h66]:
            begin
                t = b - 8'h57;
                r.valid = 1'b1;
                r.value = t[HEX_RADIX_BITS-1:0];
            end
            [8'h41:8'h46]:
            begin
                t = b - 8'h37;
                r.valid = 1'b1;
                r.value = t[HEX_RADIX_BITS-1:0];
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/hcbd_front.sv =====
// Front end: accept body bytes, run the chunk parser, classify each transfer.
`include "http_chunked_body_decoder_top_defines.svh"

module hcbd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            first_byte,
    input  logic            final_byte,
    input  logic            full,
    output logic            push,
    output hcbd_pkg::entry_t push_entry
);

    hcbd_pkg::phase_t              phase_reg, phase_next;
    logic [hcbd_pkg::SIZE_BITS-1:0] cnt_reg, cnt_next;
    logic                          sat_reg, sat_next;
    logic                          accept;

    hcbd_pkg::phase_t              cur_ph;
    hcbd_pkg::phase_t              ph;
    logic [hcbd_pkg::SIZE_BITS-1:0] cnt_dec;
    logic                          used;
    logic                          ovf;
    hcbd_pkg::hex_t                hx;
    hcbd_pkg::entry_t              ent;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign hx       = hcbd_pkg::hex_digit(in_byte);

    always_comb
    begin
        cur_ph     = first_byte ? hcbd_pkg::PH_LEAD : phase_reg;
        phase_next = cur_ph;
        cnt_next   = first_byte ? '0 : cnt_reg;
        sat_next   = first_byte ? 1'b0 : sat_reg;
        ph         = cur_ph;
        used       = 1'b0;
        ent        = '0;
        ent.mark_kind = hcbd_pkg::KIND_DATA;
        cnt_dec    = '0;
        ovf        = 1'b0;

        case (cur_ph)
            hcbd_pkg::PH_LINE_CR:
            begin
                phase_next = hcbd_pkg::PH_DATA;
                if (in_byte == hcbd_pkg::CH_LF)
                begin
                    used = 1'b1;
                end
                else
                begin
                    ph = hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA_CR:
            begin
                if (in_byte == hcbd_pkg::CH_CR)
                begin
                    phase_next = hcbd_pkg::PH_DATA_LF;
                    used = 1'b1;
                end
                else
                begin
                    phase_next = hcbd_pkg::PH_LEAD;
                    cnt_next   = '0;
                    sat_next   = 1'b0;
                    if (in_byte == hcbd_pkg::CH_LF)
                    begin
                        used = 1'b1;
                    end
                    else
                    begin
                        ph = hcbd_pkg::PH_LEAD;
                    end
                end
            end
            hcbd_pkg::PH_DATA_LF:
            begin
                phase_next = hcbd_pkg::PH_LEAD;
                cnt_next   = '0;
                sat_next   = 1'b0;
                if (in_byte == hcbd_pkg::CH_LF)
                begin
                    used = 1'b1;
                end
                else
                begin
                    ph = hcbd_pkg::PH_LEAD;
                end
            end
            default:
            begin
            end
        endcase

        if (!used)
        begin
            case (ph)
                hcbd_pkg::PH_DATA:
                begin
                    ent.has_data = 1'b1;
                    ent.data     = in_byte;
                    if (!sat_next)
                    begin
                        cnt_dec  = cnt_next - 1'b1;
                        cnt_next = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            phase_next = hcbd_pkg::PH_DATA_CR;
                        end
                    end
                end
                hcbd_pkg::PH_LEAD, hcbd_pkg::PH_HEX, hcbd_pkg::PH_EXT:
                begin
                    if (in_byte == hcbd_pkg::CH_CR || in_byte == hcbd_pkg::CH_LF)
                    begin
                        if (cnt_next == '0 && !sat_next)
                        begin
                            phase_next    = hcbd_pkg::PH_DONE;
                            ent.has_mark  = 1'b1;
                            ent.mark_kind = hcbd_pkg::KIND_DONE;
                        end
                        else if (in_byte == hcbd_pkg::CH_CR)
                        begin
                            phase_next = hcbd_pkg::PH_LINE_CR;
                        end
                        else
                        begin
                            phase_next = hcbd_pkg::PH_DATA;
                        end
                    end
                    else if (ph == hcbd_pkg::PH_LEAD &&
                             (in_byte == hcbd_pkg::CH_SP || in_byte == hcbd_pkg::CH_TAB))
                    begin
                    end
                    else if (ph != hcbd_pkg::PH_EXT && hx.valid)
                    begin
                        ovf = |cnt_next[hcbd_pkg::SIZE_BITS-1:
                                        hcbd_pkg::SIZE_BITS-hcbd_pkg::HEX_RADIX_BITS];
                        if (sat_next || ovf)
                        begin
                            cnt_next = '1;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = {cnt_next[hcbd_pkg::SIZE_BITS-hcbd_pkg::HEX_RADIX_BITS-1:0],
                                        hx.value};
                        end
                        phase_next = hcbd_pkg::PH_HEX;
                    end
                    else
                    begin
                        phase_next = hcbd_pkg::PH_EXT;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (final_byte && phase_next != hcbd_pkg::PH_DONE)
        begin
            ent.has_mark  = 1'b1;
            ent.mark_kind = hcbd_pkg::KIND_EARLY;
            phase_next    = hcbd_pkg::PH_DONE;
        end
    end

    assign push       = accept && (ent.has_data || ent.has_mark);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcbd_pkg::PH_LEAD;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
        end
    end

    `HCBD_ASSERT_SAME(a_sat_all_ones, sat_reg, cnt_reg == '1)
    `HCBD_ASSERT_NEXT(a_done_holds,
        phase_reg == hcbd_pkg::PH_DONE && !(accept && first_byte),
        phase_reg == hcbd_pkg::PH_DONE)
    `HCBD_ASSERT_SAME(a_no_push_when_full, push, !full)

endmodule

// ===== rtl/hcbd_queue.sv =====
// Short queue of classified transfers between the front and back ends.
`include "http_chunked_body_decoder_top_defines.svh"

module hcbd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hcbd_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output hcbd_pkg::entry_t head
);

    hcbd_pkg::entry_t             store_reg [hcbd_pkg::QDEPTH];
    logic [hcbd_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [hcbd_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [hcbd_pkg::QPTR_W:0]    count_reg, count_next;

    assign full      = count_reg == (hcbd_pkg::QPTR_W+1)'(hcbd_pkg::QDEPTH);
    assign not_empty = count_reg != '0;
    assign head      = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `HCBD_ASSERT_SAME(a_count_max, 1'b1,
        count_reg <= (hcbd_pkg::QPTR_W+1)'(hcbd_pkg::QDEPTH))
    `HCBD_ASSERT_SAME(a_no_pop_empty, pop, not_empty)
    `HCBD_ASSERT_SAME(a_ptr_gap,
        count_reg != (hcbd_pkg::QPTR_W+1)'(hcbd_pkg::QDEPTH),
        (wr_ptr_reg - rd_ptr_reg) == count_reg[hcbd_pkg::QPTR_W-1:0])

endmodule

// ===== rtl/hcbd_back.sv =====
// Back end: expand queued transfers into result items through an output register.
`include "http_chunked_body_decoder_top_defines.svh"

module hcbd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             not_empty,
    input  hcbd_pkg::entry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [1:0]       item_kind,
    output logic             run_end
);

    hcbd_pkg::entry_t cur_reg, cur_next;
    logic             busy_reg, busy_next;
    logic             xfer;
    logic             two_left;

    assign out_valid = busy_reg;
    assign xfer      = busy_reg && out_ready;
    assign two_left  = cur_reg.has_data && cur_reg.has_mark;

    assign out_byte  = cur_reg.has_data ? cur_reg.data : 8'h00;
    assign item_kind = cur_reg.has_data ? hcbd_pkg::KIND_DATA : cur_reg.mark_kind;
    assign run_end   = !two_left;

    always_comb
    begin
        cur_next  = cur_reg;
        busy_next = busy_reg;
        pop       = 1'b0;
        if (xfer && two_left)
        begin
            cur_next.has_data = 1'b0;
        end
        else if (!busy_reg || xfer)
        begin
            pop       = not_empty;
            busy_next = not_empty;
            if (not_empty)
            begin
                cur_next = head;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    `HCBD_ASSERT_SAME(a_marker_ends_run,
        out_valid && item_kind != hcbd_pkg::KIND_DATA, run_end)
    `HCBD_ASSERT_SAME(a_item_present, busy_reg, cur_reg.has_data || cur_reg.has_mark)
    `HCBD_ASSERT_NEXT(a_marker_follows, xfer && two_left,
        busy_reg && !cur_reg.has_data && cur_reg.has_mark)

endmodule

// ===== rtl/http_chunked_body_decoder_top.sv =====
// HTTP chunked body decoder: body bytes in, chunk payload and markers out.
//
// Input channel: in_valid/in_ready with in_byte, first_byte, final_byte.
// first_byte restarts the parser before its byte; final_byte marks the last
// buffered byte of a body. Output channel: out_valid/out_ready with out_byte,
// item_kind (payload, terminal chunk, early end) and run_end, which is set on
// the last item caused by one input transfer.
// An input transfer yields zero, one or two items. The parser updates its
// state in the cycle of the transfer, so one byte is taken every cycle while
// the queue is not full; a four-entry queue feeds an output register, which
// each item passes through after the queue. Transfers yielding two items hold
// the output register for both, which the queue absorbs until full.
// Reset puts the parser at the start of a size line with a zero count and
// empties the queue and the output register.
// When the receiver stalls, the output item holds, the queue fills, and
// in_ready drops once all four entries are occupied.
module http_chunked_body_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       first_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] item_kind,
    output logic       run_end
);

    logic             push;
    logic             pop;
    logic             full;
    logic             not_empty;
    hcbd_pkg::entry_t push_entry;
    hcbd_pkg::entry_t head;

    hcbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .final_byte (final_byte),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    hcbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    hcbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .item_kind (item_kind),
        .run_end   (run_end)
    );

endmodule
